[hw/rtl/bsm3x3_pkg.sv]
// Shared constants, types and arithmetic helpers for the 3x3 box smoother.
package bsm3x3_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    localparam int PIX_W   = 8;
    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int ROW_W   = $clog2(MAX_HEIGHT);
    localparam int DIM_W   = 11;
    localparam int CSUM_W  = PIX_W + 2;     // sum of up to three pixels
    localparam int SUM_W   = PIX_W + 4;     // sum of up to nine pixels
    localparam int TDATA_W = ((PIX_W + ROW_W + COL_W + 7) / 8) * 8;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = CFG_IDX_W'(1);

    localparam int BURST_MAX   = 4;
    localparam int BURST_CNT_W = $clog2(BURST_MAX + 1);
    localparam int FIFO_DEPTH  = 8;
    localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

    // Reciprocal constants for floor division of a nine-pixel sum
    localparam int RECIP3     = 2731;   // /3 -> >> 13, /6 -> >> 14
    localparam int RECIP9     = 3641;   // /9 -> >> 15
    localparam int RECIP_W    = 12;
    localparam int PROD_W     = SUM_W + RECIP_W;

    // Item held between the line store stage and the arithmetic stage
    typedef struct packed {
        logic             valid;
        logic             last_col;
        logic             last_row;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic [PIX_W-1:0] pixel;
        logic [PIX_W-1:0] newer;   // same column, row above
        logic [PIX_W-1:0] older;   // same column, two rows above
    } t_s1;

    typedef struct packed {
        logic             eof;
        logic             last;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic [PIX_W-1:0] smoothed;
    } t_res;

    // Up to four results released by one input beat, in output order
    typedef struct packed {
        logic [BURST_MAX-1:0] vld;
        t_res [BURST_MAX-1:0] res;
    } t_burst;

    function automatic logic [COL_W-1:0] clamp_w_m1(logic [DIM_W-1:0] v);
        if (v == '0) begin
            return '0;
        end else if (32'(v) > MAX_WIDTH) begin
            return COL_W'(MAX_WIDTH - 1);
        end else begin
            return COL_W'(v - 1'b1);
        end
    endfunction

    function automatic logic [ROW_W-1:0] clamp_h_m1(logic [DIM_W-1:0] v);
        if (v == '0) begin
            return '0;
        end else if (32'(v) > MAX_HEIGHT) begin
            return ROW_W'(MAX_HEIGHT - 1);
        end else begin
            return ROW_W'(v - 1'b1);
        end
    endfunction

    // floor(sum / (nr * nc)) for nr, nc in 1..3
    function automatic logic [PIX_W-1:0] div_box(logic [SUM_W-1:0] sum,
                                                 logic [1:0] nr, logic [1:0] nc);
        logic [3:0]        cnt;
        logic [PROD_W-1:0] p3;
        logic [PROD_W-1:0] p9;
        logic [PIX_W-1:0]  q;
        cnt = 4'(nr) * 4'(nc);
        p3  = PROD_W'(sum) * PROD_W'(RECIP3);
        p9  = PROD_W'(sum) * PROD_W'(RECIP9);
        case (cnt)
            4'd1:    q = PIX_W'(sum);
            4'd2:    q = PIX_W'(sum >> 1);
            4'd3:    q = PIX_W'(p3 >> 13);
            4'd4:    q = PIX_W'(sum >> 2);
            4'd6:    q = PIX_W'(p3 >> 14);
            4'd9:    q = PIX_W'(p9 >> 15);
            default: q = '0;
        endcase
        return q;
    endfunction

endpackage

[hw/rtl/bsm3x3_lbuf.sv]
// Raster counters, two-row line store and the first pipeline register.
module bsm3x3_lbuf
    import bsm3x3_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [PIX_W-1:0] i_pixel,
    input  logic [COL_W-1:0] i_w_m1,
    input  logic [ROW_W-1:0] i_h_m1,
    output t_s1              o_s1
);

    logic [COL_W-1:0]   r_col, n_col;
    logic [ROW_W-1:0]   r_row, n_row;
    logic               last_col, last_row;

    // {older, newer} per column
    logic [2*PIX_W-1:0] r_mem [MAX_WIDTH];
    logic [2*PIX_W-1:0] r_rd;
    logic               r_fwd;
    logic [2*PIX_W-1:0] r_fwd_data;
    logic [2*PIX_W-1:0] rd_data;

    logic               r_vld;
    logic               r_lc, r_lr;
    logic [ROW_W-1:0]   r_srow;
    logic [COL_W-1:0]   r_scol;
    logic [PIX_W-1:0]   r_pix;

    assign last_col = (r_col >= i_w_m1);
    assign last_row = (r_row >= i_h_m1);

    always_comb begin
        n_col = r_col + 1'b1;
        n_row = r_row;
        if (last_col) begin
            n_col = '0;
            n_row = last_row ? '0 : r_row + 1'b1;
        end
    end

    // The stage ahead writes the column we read when the row is one pixel wide
    assign rd_data = r_fwd ? r_fwd_data : r_rd;

    always_comb begin
        o_s1.valid    = r_vld;
        o_s1.last_col = r_lc;
        o_s1.last_row = r_lr;
        o_s1.row      = r_srow;
        o_s1.col      = r_scol;
        o_s1.pixel    = r_pix;
        o_s1.older    = rd_data[2*PIX_W-1:PIX_W];
        o_s1.newer    = rd_data[PIX_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            r_vld <= 1'b0;
            r_fwd <= 1'b0;
        end else begin
            r_vld <= i_accept;
            r_fwd <= i_accept && r_vld && (r_scol == r_col);
            if (i_accept) begin
                r_col <= n_col;
                r_row <= n_row;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_rd       <= r_mem[r_col];
            r_fwd_data <= {rd_data[PIX_W-1:0], r_pix};
            r_pix      <= i_pixel;
            r_srow     <= r_row;
            r_scol     <= r_col;
            r_lc       <= last_col;
            r_lr       <= last_row;
        end
        if (r_vld) begin
            r_mem[r_scol] <= {rd_data[PIX_W-1:0], r_pix};
        end
    end

endmodule

[hw/rtl/bsm3x3_core.sv]
// Column window and neighborhood averages for the results of one beat.
module bsm3x3_core
    import bsm3x3_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_s1              i_s1,
    input  logic [COL_W-1:0] i_w_m1,
    input  logic [ROW_W-1:0] i_h_m1,
    output t_burst           o_burst
);

    // index 0: two rows up, 1: row up, 2: current row
    logic [2:0][PIX_W-1:0] r_wm;    // column c-1
    logic [2:0][PIX_W-1:0] r_wl;    // column c-2
    logic [2:0][PIX_W-1:0] cur;

    logic             up1, up2, has_l, has_m;
    logic [1:0]       nr_a, nr_b, nc_lr, nc_r;
    logic [SUM_W-1:0] sum0, sum1, sum2, sum3;
    logic [ROW_W-1:0] row_p;
    logic [COL_W-1:0] col_p;

    // rows above plus the row below (output one row up)
    function automatic logic [CSUM_W-1:0] cs_up(logic [2:0][PIX_W-1:0] c, logic up);
        return (up ? CSUM_W'(c[0]) : '0) + CSUM_W'(c[1]) + CSUM_W'(c[2]);
    endfunction

    // row above plus own row (output on the current row)
    function automatic logic [CSUM_W-1:0] cs_dn(logic [2:0][PIX_W-1:0] c, logic up);
        return (up ? CSUM_W'(c[1]) : '0) + CSUM_W'(c[2]);
    endfunction

    function automatic t_res mk(logic [PIX_W-1:0] v, logic [ROW_W-1:0] r,
                                logic [COL_W-1:0] c, logic [ROW_W-1:0] hm,
                                logic [COL_W-1:0] wm);
        t_res x;
        x.smoothed = v;
        x.row      = r;
        x.col      = c;
        x.last     = 1'b0;
        x.eof      = (r == hm) && (c == wm);
        return x;
    endfunction

    assign cur = {i_s1.pixel, i_s1.newer, i_s1.older};

    always_comb begin
        up1   = (i_s1.row >= ROW_W'(2));
        up2   = (i_s1.row != '0);
        has_l = (i_s1.col >= COL_W'(2));
        has_m = (i_s1.col != '0);
        nr_a  = up1 ? 2'd3 : 2'd2;
        nr_b  = up2 ? 2'd2 : 2'd1;
        nc_lr = has_l ? 2'd3 : 2'd2;
        nc_r  = has_m ? 2'd2 : 2'd1;
        row_p = i_s1.row - 1'b1;
        col_p = i_s1.col - 1'b1;

        sum0 = (has_l ? SUM_W'(cs_up(r_wl, up1)) : '0) + SUM_W'(cs_up(r_wm, up1))
             + SUM_W'(cs_up(cur, up1));
        sum1 = (has_m ? SUM_W'(cs_up(r_wm, up1)) : '0) + SUM_W'(cs_up(cur, up1));
        sum2 = (has_l ? SUM_W'(cs_dn(r_wl, up2)) : '0) + SUM_W'(cs_dn(r_wm, up2))
             + SUM_W'(cs_dn(cur, up2));
        sum3 = (has_m ? SUM_W'(cs_dn(r_wm, up2)) : '0) + SUM_W'(cs_dn(cur, up2));

        o_burst.vld[0] = i_s1.valid && up2 && has_m;
        o_burst.vld[1] = i_s1.valid && up2 && i_s1.last_col;
        o_burst.vld[2] = i_s1.valid && i_s1.last_row && has_m;
        o_burst.vld[3] = i_s1.valid && i_s1.last_row && i_s1.last_col;

        o_burst.res[0] = mk(div_box(sum0, nr_a, nc_lr), row_p, col_p, i_h_m1, i_w_m1);
        o_burst.res[1] = mk(div_box(sum1, nr_a, nc_r), row_p, i_s1.col, i_h_m1, i_w_m1);
        o_burst.res[2] = mk(div_box(sum2, nr_b, nc_lr), i_s1.row, col_p, i_h_m1, i_w_m1);
        o_burst.res[3] = mk(div_box(sum3, nr_b, nc_r), i_s1.row, i_s1.col,
                            i_h_m1, i_w_m1);

        // last present result of the beat closes the run
        o_burst.res[0].last = o_burst.vld[0] && !(|o_burst.vld[3:1]);
        o_burst.res[1].last = o_burst.vld[1] && !(|o_burst.vld[3:2]);
        o_burst.res[2].last = o_burst.vld[2] && !o_burst.vld[3];
        o_burst.res[3].last = o_burst.vld[3];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wm <= '0;
            r_wl <= '0;
        end else if (i_s1.valid) begin
            r_wl <= r_wm;
            r_wm <= cur;
        end
    end

endmodule

[hw/rtl/bsm3x3_ofifo.sv]
// Result queue: takes up to four results a cycle, hands out one.
module bsm3x3_ofifo
    import bsm3x3_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_burst i_burst,
    output logic   o_room,
    output logic   o_valid,
    input  logic   i_ready,
    output t_res   o_res
);

    t_res                   r_q [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]  r_wr, r_rd;
    logic [FIFO_CNT_W-1:0]  r_cnt;
    logic [FIFO_PTR_W-1:0]  pos [BURST_MAX];
    logic [BURST_CNT_W-1:0] n_push;
    logic                   pop;

    always_comb begin
        pos[0] = '0;
        for (int i = 1; i < BURST_MAX; i++) begin
            pos[i] = pos[i-1] + FIFO_PTR_W'(i_burst.vld[i-1]);
        end
        n_push = BURST_CNT_W'($countones(i_burst.vld));
    end

    // room for a full burst from the beat accepted now, after this cycle's push
    assign o_room  = (FIFO_CNT_W'(r_cnt) + FIFO_CNT_W'(n_push))
                     <= FIFO_CNT_W'(FIFO_DEPTH - BURST_MAX);
    assign o_valid = (r_cnt != '0);
    assign o_res   = r_q[r_rd];
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < FIFO_DEPTH; j++) begin
            for (int i = 0; i < BURST_MAX; i++) begin
                if (i_burst.vld[i] && ((r_wr + pos[i]) == FIFO_PTR_W'(j))) begin
                    r_q[j] <= i_burst.res[i];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= r_wr + FIFO_PTR_W'(n_push);
            r_rd  <= r_rd + FIFO_PTR_W'(pop);
            r_cnt <= r_cnt + FIFO_CNT_W'(n_push) - FIFO_CNT_W'(pop);
        end
    end

endmodule

[hw/rtl/box_smoother_3x3_edge_aware.sv]
// Top level of the edge-aware 3x3 box smoother.
//
// Pixels enter on s_axis in raster order, one 8-bit pixel per beat. Each
// smoothed pixel leaves on m_axis with its row and column; tlast marks the
// last result released by one input beat, tuser marks the frame's last pixel.
// Outputs trail the input by one row and one column; during the last row a
// beat releases results of both remaining rows, up to four per beat.
// Frame size is set on the cfg write channel (index 0 width, 1 height,
// 1..1024 each, 0 read as 1, larger values clipped); write it between frames.
// A result released by an accepted beat passes the line store read stage
// and then the result queue before it is valid on m_axis.
// Throughput: one beat per clock while each beat releases at most one result
// and m_axis_tready holds high; in the last row the single output port, one result
// per clock, sets the rate and an eight-entry result queue throttles s_axis_tready.
// When the receiver stalls, results wait in the queue and input keeps flowing
// until the queue could not take a further four-result burst.
// Reset clears counters, column window and queue and sets both sizes to 1024.
// The line store is not cleared: the first rows of a frame never use its stale entries.
module box_smoother_3x3_edge_aware
    import bsm3x3_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [PIX_W-1:0]     s_axis_tdata,    // [7:0] pixel_in
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [TDATA_W-1:0]   m_axis_tdata,    // smoothed, out_row, out_col, zero pad
    output logic                 m_axis_tlast,
    output logic                 m_axis_tuser,    // end_of_frame
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DIM_W-1:0]     i_cfg_data
);

    logic [COL_W-1:0] r_w_m1;
    logic [ROW_W-1:0] r_h_m1;
    logic             accept;
    logic             room;
    t_s1              s1;
    t_burst           burst;
    t_res             res;

    assign o_cfg_ready   = 1'b1;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = room;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_m1 <= COL_W'(MAX_WIDTH - 1);
            r_h_m1 <= ROW_W'(MAX_HEIGHT - 1);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_IDX_WIDTH:  r_w_m1 <= clamp_w_m1(i_cfg_data);
                CFG_IDX_HEIGHT: r_h_m1 <= clamp_h_m1(i_cfg_data);
                default: ;
            endcase
        end
    end

    bsm3x3_lbuf u_lbuf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_pixel  (s_axis_tdata),
        .i_w_m1   (r_w_m1),
        .i_h_m1   (r_h_m1),
        .o_s1     (s1)
    );

    bsm3x3_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_s1    (s1),
        .i_w_m1  (r_w_m1),
        .i_h_m1  (r_h_m1),
        .o_burst (burst)
    );

    bsm3x3_ofifo u_ofifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_burst (burst),
        .o_room  (room),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_res   (res)
    );

    assign m_axis_tdata = TDATA_W'({res.col, res.row, res.smoothed});
    assign m_axis_tlast = res.last;
    assign m_axis_tuser = res.eof;

endmodule

[hw/rtl/bsm3x3_chk.sv]
// Port-level checks for the box smoother, bound to the top level.
module bsm3x3_chk
    import bsm3x3_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               s_axis_tready,
    input logic               m_axis_tvalid,
    input logic               m_axis_tready,
    input logic [TDATA_W-1:0] m_axis_tdata,
    input logic               m_axis_tlast,
    input logic               m_axis_tuser
);

    // queue comes out of reset empty
    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid right after reset");

    a_rst_ready: assert property (@(posedge i_clk) !i_rst_n |=> s_axis_tready)
        else $error("input not ready right after reset");

    // the frame's last pixel is always the final result of its beat
    a_eof_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
        else $error("end of frame without tlast");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tlast) && $stable(m_axis_tuser))
        else $error("stalled output beat changed");

endmodule

bind box_smoother_3x3_edge_aware bsm3x3_chk u_chk (.*);
